@@ rtl/rcfe_pkg.sv @@
// shared types and constants of the rc channel frame encoder
package rcfe_pkg;

    // field widths
    localparam int PULSE_W   = 12;
    localparam int TICK_W    = 11;
    localparam int CHAN_W    = 4;
    localparam int NUM_CHANS = 16;
    localparam int PAYLOAD_W = NUM_CHANS * TICK_W;
    localparam int POS_W     = 5;

    // operation codes of an input word
    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_CENTER = 2'd1,
        OP_SEND   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MIN    = 2'd0,
        REG_MAX    = 2'd1,
        REG_CENTER = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // frame constants
    localparam logic [7:0] SYNC_BYTE   = 8'hC8;
    localparam logic [7:0] LENGTH_BYTE = 8'd24;
    localparam logic [7:0] TYPE_BYTE   = 8'h16;
    localparam logic [7:0] CRC_POLY    = 8'hD5;

    // byte positions within the frame
    localparam logic [POS_W-1:0] POS_SYNC     = 5'd0;
    localparam logic [POS_W-1:0] POS_LENGTH   = 5'd1;
    localparam logic [POS_W-1:0] POS_TYPE     = 5'd2;
    localparam logic [POS_W-1:0] POS_PAY_LAST = 5'd24;
    localparam logic [POS_W-1:0] POS_CRC      = 5'd25;

    // reset values
    localparam logic [PULSE_W-1:0] MIN_RESET    = 12'd1000;
    localparam logic [PULSE_W-1:0] MAX_RESET    = 12'd2000;
    localparam logic [PULSE_W-1:0] CENTER_RESET = 12'd1500;

endpackage

@@ rtl/rcfe_tick_unit.sv @@
// shared pulse-to-tick converter with a registered reciprocal multiply
module rcfe_tick_unit
(
    input  logic                        clk,
    input  logic [rcfe_pkg::PULSE_W-1:0] pulse_us,
    output logic [rcfe_pkg::TICK_W-1:0]  ticks
);
    import rcfe_pkg::*;

    // pulses below this give a negative offset and map to zero ticks
    localparam logic [PULSE_W-1:0] PULSE_FLOOR = 12'd880;
    // 2*(8*us - 7040) + 5 = 16*us - 14075
    localparam logic [16:0]        OFFSET      = 17'd14075;
    // floor(x / 10) = (x * 0xCCCD) >> 19 for any 16-bit x
    localparam logic [15:0]        RECIP_10    = 16'hCCCD;
    localparam logic [12:0]        TICK_SAT    = 13'd2047;

    logic [16:0] scaled;
    logic [15:0] dividend;
    logic [31:0] prod_reg;
    logic        neg_reg;
    logic [12:0] quot;

    // rounding offset, then divide by ten through the reciprocal
    assign scaled   = {1'b0, pulse_us, 4'b0000} - OFFSET;
    assign dividend = scaled[15:0];

    always_ff @(posedge clk)
    begin
        prod_reg <= {16'h0000, dividend} * {16'h0000, RECIP_10};
        neg_reg  <= (pulse_us < PULSE_FLOOR);
    end

    // saturate at the top of the 11-bit range
    assign quot = prod_reg[31:19];

    always_comb
    begin
        if (neg_reg)
        begin
            ticks = '0;
        end
        else if (quot > TICK_SAT)
        begin
            ticks = TICK_SAT[TICK_W-1:0];
        end
        else
        begin
            ticks = quot[TICK_W-1:0];
        end
    end

endmodule

@@ rtl/rcfe_crc8.sv @@
// running crc-8 over frame bytes, polynomial 0xd5, msb first
module rcfe_crc8
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       clear,
    input  logic       enable,
    input  logic [7:0] data_byte,
    output logic [7:0] crc
);
    import rcfe_pkg::*;

    logic [7:0] crc_reg;
    logic [7:0] crc_next;

    // eight shift steps of one byte
    always_comb
    begin
        logic [7:0] acc;
        acc = crc_reg ^ data_byte;
        for (int i = 0; i < 8; i++)
        begin
            if (acc[7])
            begin
                acc = {acc[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                acc = {acc[6:0], 1'b0};
            end
        end
        crc_next = acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= '0;
        end
        else if (clear)
        begin
            crc_reg <= '0;
        end
        else if (enable)
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

@@ rtl/rc_channel_frame_encoder.sv @@
// top level: channel store, frame sequencer and output register
//
// Keeps sixteen channel pulse widths and sends packed rc channel frames of
// 26 bytes (sync, length, type, 22 payload bytes, crc-8). A set-channel or
// center-all word is taken without leaving the idle state. A send word has
// the single shared tick converter walk through the sixteen channels one
// per cycle through its multiply register, then 26 bytes leave one
// per cycle when m_tready stays high; the input side is not ready from the
// send word until the last frame byte is loaded into the output register.
// Configuration writes are always accepted and apply from the next cycle.
module rc_channel_frame_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // operation[1:0], channel_index[5:2], pulse_us[17:6], zeros
    // frame bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // frame_byte[7:0]
    output logic        m_tlast    // last_byte
);
    import rcfe_pkg::*;

    state_t                 state_reg, state_next;
    logic [POS_W-1:0]       cnt_reg, cnt_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   pipe_valid_reg, pipe_valid_next;
    logic [PAYLOAD_W-1:0]   payload_reg, payload_next;
    logic [PULSE_W-1:0]     chan_reg [NUM_CHANS];
    logic [PULSE_W-1:0]     min_reg, max_reg, center_reg;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [7:0]             m_tdata_reg, m_tdata_next;
    logic                   m_tlast_reg, m_tlast_next;

    op_t                    in_op;
    logic [CHAN_W-1:0]      in_chan;
    logic [PULSE_W-1:0]     in_pulse;
    logic [PULSE_W-1:0]     raised, clamped;
    logic                   in_accept;
    logic                   out_load;
    logic [TICK_W-1:0]      ticks;
    logic [7:0]             emit_byte;
    logic [7:0]             crc;
    logic                   crc_clear, crc_enable;

    // input word fields
    assign in_op     = op_t'(s_tdata[1:0]);
    assign in_chan   = s_tdata[5:2];
    assign in_pulse  = s_tdata[17:6];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // clamp: raise to minimum first, then lower to maximum
    assign raised  = (in_pulse < min_reg) ? min_reg : in_pulse;
    assign clamped = (raised > max_reg) ? max_reg : raised;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg    <= MIN_RESET;
            max_reg    <= MAX_RESET;
            center_reg <= CENTER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MIN:    min_reg    <= cfg_data;
                REG_MAX:    max_reg    <= cfg_data;
                REG_CENTER: center_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // channel store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANS; i++)
            begin
                chan_reg[i] <= CENTER_RESET;
            end
        end
        else if (in_accept)
        begin
            case (in_op)
                OP_SET:
                begin
                    chan_reg[in_chan] <= clamped;
                end
                OP_CENTER:
                begin
                    for (int i = 0; i < NUM_CHANS; i++)
                    begin
                        chan_reg[i] <= center_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // shared converter, fed one channel per cycle
    rcfe_tick_unit u_tick
    (
        .clk      (clk),
        .pulse_us (chan_reg[cnt_reg[CHAN_W-1:0]]),
        .ticks    (ticks)
    );

    // byte for the current frame position
    always_comb
    begin
        case (pos_reg)
            POS_SYNC:   emit_byte = SYNC_BYTE;
            POS_LENGTH: emit_byte = LENGTH_BYTE;
            POS_TYPE:   emit_byte = TYPE_BYTE;
            POS_CRC:    emit_byte = crc;
            default:    emit_byte = payload_reg[7:0];
        endcase
    end

    assign out_load   = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign crc_clear  = in_accept && (in_op == OP_SEND);
    assign crc_enable = out_load && (pos_reg >= POS_TYPE) && (pos_reg <= POS_PAY_LAST);

    rcfe_crc8 u_crc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (crc_clear),
        .enable    (crc_enable),
        .data_byte (emit_byte),
        .crc       (crc)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        pipe_valid_next = 1'b0;
        payload_next    = payload_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg && !m_tready;

        // packed channels shift in from the top, channel 0 ends at bit 0
        if (pipe_valid_reg)
        begin
            payload_next = {ticks, payload_reg[PAYLOAD_W-1:TICK_W]};
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (in_op == OP_SEND))
                begin
                    state_next = ST_CONV;
                    cnt_next   = '0;
                end
            end
            ST_CONV:
            begin
                if (cnt_reg == POS_W'(NUM_CHANS))
                begin
                    state_next = ST_EMIT;
                    pos_next   = POS_SYNC;
                end
                else
                begin
                    pipe_valid_next = 1'b1;
                    cnt_next        = cnt_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = emit_byte;
                    m_tlast_next  = (pos_reg == POS_CRC);
                    pos_next      = pos_reg + 1'b1;
                    if ((pos_reg > POS_TYPE) && (pos_reg <= POS_PAY_LAST))
                    begin
                        payload_next = {8'h00, payload_reg[PAYLOAD_W-1:8]};
                    end
                    if (pos_reg == POS_CRC)
                    begin
                        state_next = ST_IDLE;
                        pos_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pos_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tlast_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pos_reg        <= pos_next;
            pipe_valid_reg <= pipe_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tlast_reg    <= m_tlast_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // a last marker only travels with a valid word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tlast_reg |-> m_tvalid_reg)
        else $error("last marker without valid word");

    // loading the crc byte marks the word as last and frees the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (pos_reg == POS_CRC)) |=> (m_tlast_reg && s_tready))
        else $error("crc byte not marked last");

    // a send word starts the conversion walk at channel 0
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_op == OP_SEND)) |=> ((state_reg == ST_CONV) && (cnt_reg == '0)))
        else $error("send word did not start conversion");

    // converter results only arrive during the conversion walk
    assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid_reg |-> (state_reg == ST_CONV))
        else $error("tick result outside conversion");

endmodule
